FILE: hw/rtl/sji_pkg.sv
// shared types and constants of the snapshot jitter interpolator
package sji_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTITY_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY     = 2'd2;

    localparam logic [15:0] DELAY_RESET = 16'd6554;

    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_STALE   = 3'd1;
    localparam logic [2:0] ST_IGNORED = 3'd2;
    localparam logic [2:0] ST_NO_DATA = 3'd3;
    localparam logic [2:0] ST_HELD    = 3'd4;
    localparam logic [2:0] ST_INTERP  = 3'd5;

    // 0.9995 and 1e-6 in Q28
    localparam logic signed [33:0] DOT_LERP_LIMIT = 34'sd268301238;
    localparam logic [31:0]        LEN_LIMIT      = 32'd268;

    localparam logic [5:0] T_STEPS    = 6'd16;
    localparam logic [5:0] NORM_STEPS = 6'd29;
    localparam logic [5:0] SQRT_STEPS = 6'd32;

    typedef logic signed [31:0] t_q28;

    typedef struct packed {
        logic               action;
        logic [15:0]        sender_id;
        logic [15:0]        seq_number;
        logic [31:0]        now_time;
        logic signed [31:0] in_pos_x;
        logic signed [31:0] in_pos_y;
        logic signed [31:0] in_pos_z;
        logic signed [15:0] in_rot_x;
        logic signed [15:0] in_rot_y;
        logic signed [15:0] in_rot_z;
        logic signed [15:0] in_rot_w;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [15:0] out_rot_x;
        logic signed [15:0] out_rot_y;
        logic signed [15:0] out_rot_z;
        logic signed [15:0] out_rot_w;
    } t_out_item;

    typedef struct packed {
        logic [31:0]        slot_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
        logic signed [15:0] rot_w;
    } t_slot;

    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic [35:0] init_rem;
        logic [63:0] bits;
        logic [31:0] divisor;
        logic [5:0]  steps;
    } t_ds_cmd;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] result;
    } t_ds_rsp;

endpackage

FILE: hw/rtl/sji_if.sv
// valid/ready channels for items and results
interface sji_in_if import sji_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sji_out_if import sji_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/snapshot_jitter_interpolator.sv
// top level: snapshot store, slot scan and pose interpolation sequencer
//
//  channel   dir  handshake              payload
//  i_in      in   i_in.valid/ready       t_in_item (store or render query)
//  o_out     out  o_out.valid/ready      t_out_item (status and pose)
//  i_cfg_*   in   i_cfg_we               i_cfg_idx, i_cfg_data
//
// one item at a time; a store is decided in decode, a query scans every slot
// interpolation takes a lerp path or a slerp path, both run on the shared
// shift-subtract unit (32-step root, 29-step divide)
// the next item is taken while a result waits in the output register
// synchronous active-low reset empties all slots at once
module snapshot_jitter_interpolator import sji_pkg::*; #(
    parameter int SLOTS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sji_in_if.sink                i_in,
    sji_out_if.source             o_out
);
    localparam int AW = $clog2(SLOTS);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DECODE    = 5'd1;
    localparam logic [4:0] S_SCAN_RD   = 5'd2;
    localparam logic [4:0] S_SCAN_CMP  = 5'd3;
    localparam logic [4:0] S_SCAN_END  = 5'd4;
    localparam logic [4:0] S_LOAD_P    = 5'd5;
    localparam logic [4:0] S_LOAD_N    = 5'd6;
    localparam logic [4:0] S_DIV_T     = 5'd7;
    localparam logic [4:0] S_POS_MUL   = 5'd8;
    localparam logic [4:0] S_POS_ADD   = 5'd9;
    localparam logic [4:0] S_DOT_MUL   = 5'd10;
    localparam logic [4:0] S_DOT_ADD   = 5'd11;
    localparam logic [4:0] S_DOT_END   = 5'd12;
    localparam logic [4:0] S_LERP_MUL  = 5'd13;
    localparam logic [4:0] S_LERP_ADD  = 5'd14;
    localparam logic [4:0] S_BIS_SUM   = 5'd15;
    localparam logic [4:0] S_BIS_UPD   = 5'd16;
    localparam logic [4:0] S_NSQ_MUL   = 5'd17;
    localparam logic [4:0] S_NSQ_ADD   = 5'd18;
    localparam logic [4:0] S_NSQRT_GO  = 5'd19;
    localparam logic [4:0] S_NSQRT     = 5'd20;
    localparam logic [4:0] S_NCHK      = 5'd21;
    localparam logic [4:0] S_NDIV_GO   = 5'd22;
    localparam logic [4:0] S_NDIV_WAIT = 5'd23;
    localparam logic [4:0] S_FINISH    = 5'd24;
    localparam logic [4:0] S_DONE      = 5'd25;

    logic [15:0] r_entity_id;
    logic        r_locally_owned;
    logic [15:0] r_render_delay;

    logic [4:0]        r_state;
    t_in_item          r_item;
    t_out_item         r_res;
    t_out_item         r_out;
    logic              r_out_valid;
    logic [15:0]       r_last_seq;
    logic [AW-1:0]     r_write_slot;

    logic [AW-1:0]     r_idx;
    logic              r_prev_ok;
    logic [AW-1:0]     r_prev_idx;
    logic [31:0]       r_prev_time;
    logic              r_next_ok;
    logic [AW-1:0]     r_next_idx;
    logic [31:0]       r_next_time;
    logic signed [33:0] r_render;

    logic signed [31:0] r_p_pos [3];
    logic signed [31:0] r_n_pos [3];
    logic signed [31:0] r_pos [3];
    logic signed [15:0] r_p_rot [4];
    logic signed [15:0] r_n_rot [4];
    t_q28               r_pq [4];
    t_q28               r_nq [4];
    t_q28               r_s [4];
    t_q28               r_m [4];
    logic [15:0]        r_t;
    logic [3:0]         r_bit;
    logic [1:0]         r_k;
    logic signed [33:0] r_dot;
    logic [63:0]        r_sum;
    logic [31:0]        r_len;
    logic               r_final;

    t_slot              w_rd;
    t_slot              w_wdata;
    logic               w_slot_we;
    logic [AW-1:0]      w_raddr;
    t_ds_cmd            w_ds_cmd;
    t_ds_rsp            w_ds_rsp;
    logic signed [32:0] w_mul_a;
    logic signed [32:0] w_mul_b;
    logic signed [65:0] w_prod;
    logic signed [65:0] w_round;
    logic [15:0]        w_delta;
    logic               w_accept_store;
    logic signed [33:0] w_ti;
    logic [31:0]        w_abs;
    logic               w_dot_neg;
    logic signed [33:0] w_dot_abs;
    logic [31:0]        w_limit;
    logic [15:0]        w_orot [4];
    logic signed [33:0] w_rext;

    // result with a status and a zero pose
    function automatic t_out_item res_of(input logic [2:0] st);
        t_out_item res;
        res        = '0;
        res.status = st;
        return res;
    endfunction

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entity_id     <= '0;
            r_locally_owned <= 1'b0;
            r_render_delay  <= DELAY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENTITY_ID: r_entity_id     <= i_cfg_data;
                CFG_LOCAL:     r_locally_owned <= i_cfg_data[0];
                CFG_DELAY:     r_render_delay  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sji_slots #(.SLOTS(SLOTS)) u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_slot_we),
        .i_waddr (r_write_slot),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    sji_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_ds_cmd),
        .o_rsp   (w_ds_rsp)
    );

    sji_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    assign w_delta        = r_item.seq_number - r_last_seq;
    assign w_accept_store = (r_item.sender_id == r_entity_id) && !r_locally_owned
                            && (w_delta != 16'd0) && !w_delta[15];
    assign w_slot_we      = (r_state == S_DECODE) && !r_item.action && w_accept_store;

    always_comb begin
        w_wdata.slot_time = r_item.now_time;
        w_wdata.pos_x     = r_item.in_pos_x;
        w_wdata.pos_y     = r_item.in_pos_y;
        w_wdata.pos_z     = r_item.in_pos_z;
        w_wdata.rot_x     = r_item.in_rot_x;
        w_wdata.rot_y     = r_item.in_rot_y;
        w_wdata.rot_z     = r_item.in_rot_z;
        w_wdata.rot_w     = r_item.in_rot_w;
    end

    always_comb begin
        case (r_state)
            S_SCAN_END: w_raddr = r_prev_idx;
            S_LOAD_P:   w_raddr = r_next_idx;
            default:    w_raddr = r_idx;
        endcase
    end

    assign w_ti      = signed'({2'b00, w_rd.slot_time});
    assign w_abs     = r_s[r_k][31] ? (32'd0 - r_s[r_k]) : r_s[r_k];
    assign w_dot_neg = r_dot[33];
    assign w_dot_abs = w_dot_neg ? -r_dot : r_dot;
    assign w_limit   = r_final ? LEN_LIMIT : 32'd0;
    assign w_round   = (w_prod + 66'sd32768) >>> 16;

    // shared unit commands
    always_comb begin
        w_ds_cmd = '0;
        case (r_state)
            S_LOAD_N: begin
                w_ds_cmd.start    = 1'b1;
                w_ds_cmd.init_rem = {4'b0000, r_render[31:0] - r_prev_time};
                w_ds_cmd.divisor  = r_next_time - r_prev_time;
                w_ds_cmd.steps    = T_STEPS;
            end
            S_NSQRT_GO: begin
                w_ds_cmd.start   = 1'b1;
                w_ds_cmd.is_sqrt = 1'b1;
                w_ds_cmd.bits    = r_sum;
                w_ds_cmd.steps   = SQRT_STEPS;
            end
            S_NDIV_GO: begin
                w_ds_cmd.start    = 1'b1;
                w_ds_cmd.init_rem = {5'b00000, w_abs[31:1]};
                w_ds_cmd.bits     = {w_abs[0], 63'd0};
                w_ds_cmd.divisor  = r_len;
                w_ds_cmd.steps    = NORM_STEPS;
            end
            default: ;
        endcase
    end

    // multiplier operand selection
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_POS_MUL: begin
                w_mul_a = {r_n_pos[r_k][31], r_n_pos[r_k]}
                          - {r_p_pos[r_k][31], r_p_pos[r_k]};
                w_mul_b = {17'd0, r_t};
            end
            S_DOT_MUL: begin
                w_mul_a = {{17{r_p_rot[r_k][15]}}, r_p_rot[r_k]};
                w_mul_b = {{17{r_n_rot[r_k][15]}}, r_n_rot[r_k]};
            end
            S_LERP_MUL: begin
                w_mul_a = {r_nq[r_k][31], r_nq[r_k]} - {r_pq[r_k][31], r_pq[r_k]};
                w_mul_b = {17'd0, r_t};
            end
            S_NSQ_MUL: begin
                w_mul_a = {r_s[r_k][31], r_s[r_k]};
                w_mul_b = {r_s[r_k][31], r_s[r_k]};
            end
            default: ;
        endcase
    end

    // final rounding of the rotation to Q2.14
    always_comb begin
        w_rext = '0;
        for (int i = 0; i < 4; i++) begin
            w_rext     = ({{2{r_m[i][31]}}, r_m[i]} + 34'sd8192) >>> 14;
            w_orot[i]  = w_rext[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_last_seq   <= '0;
            r_write_slot <= '0;
        end else begin
            if (r_state == S_DONE && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_item  <= i_in.payload;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (!r_item.action) begin
                        r_state <= S_DONE;
                        if (r_item.sender_id != r_entity_id || r_locally_owned) begin
                            r_res <= res_of(ST_IGNORED);
                        end else if (!w_accept_store) begin
                            r_res <= res_of(ST_STALE);
                        end else begin
                            r_res        <= res_of(ST_STORED);
                            r_last_seq   <= r_item.seq_number;
                            r_write_slot <= (r_write_slot == AW'(SLOTS - 1)) ? '0
                                            : r_write_slot + 1'b1;
                        end
                    end else if (r_locally_owned) begin
                        r_res   <= res_of(ST_IGNORED);
                        r_state <= S_DONE;
                    end else begin
                        r_render  <= signed'({2'b00, r_item.now_time})
                                     - signed'({18'd0, r_render_delay});
                        r_idx     <= '0;
                        r_prev_ok <= 1'b0;
                        r_next_ok <= 1'b0;
                        r_state   <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CMP;
                end
                S_SCAN_CMP: begin
                    if (w_rd.slot_time != 32'd0) begin
                        if (w_ti <= r_render) begin
                            if (!r_prev_ok || w_rd.slot_time > r_prev_time) begin
                                r_prev_ok   <= 1'b1;
                                r_prev_idx  <= r_idx;
                                r_prev_time <= w_rd.slot_time;
                            end
                        end else begin
                            if (!r_next_ok || w_rd.slot_time < r_next_time) begin
                                r_next_ok   <= 1'b1;
                                r_next_idx  <= r_idx;
                                r_next_time <= w_rd.slot_time;
                            end
                        end
                    end
                    if (r_idx == AW'(SLOTS - 1)) begin
                        r_state <= S_SCAN_END;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SCAN_END: begin
                    if (!r_prev_ok) begin
                        r_res   <= res_of(ST_NO_DATA);
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_LOAD_P;
                    end
                end
                S_LOAD_P: begin
                    r_p_pos[0] <= w_rd.pos_x;
                    r_p_pos[1] <= w_rd.pos_y;
                    r_p_pos[2] <= w_rd.pos_z;
                    r_p_rot[0] <= w_rd.rot_x;
                    r_p_rot[1] <= w_rd.rot_y;
                    r_p_rot[2] <= w_rd.rot_z;
                    r_p_rot[3] <= w_rd.rot_w;
                    if (!r_next_ok) begin
                        r_res.status    <= ST_HELD;
                        r_res.out_pos_x <= w_rd.pos_x;
                        r_res.out_pos_y <= w_rd.pos_y;
                        r_res.out_pos_z <= w_rd.pos_z;
                        r_res.out_rot_x <= w_rd.rot_x;
                        r_res.out_rot_y <= w_rd.rot_y;
                        r_res.out_rot_z <= w_rd.rot_z;
                        r_res.out_rot_w <= w_rd.rot_w;
                        r_state         <= S_DONE;
                    end else begin
                        r_state <= S_LOAD_N;
                    end
                end
                S_LOAD_N: begin
                    r_n_pos[0] <= w_rd.pos_x;
                    r_n_pos[1] <= w_rd.pos_y;
                    r_n_pos[2] <= w_rd.pos_z;
                    r_n_rot[0] <= w_rd.rot_x;
                    r_n_rot[1] <= w_rd.rot_y;
                    r_n_rot[2] <= w_rd.rot_z;
                    r_n_rot[3] <= w_rd.rot_w;
                    r_state    <= S_DIV_T;
                end
                S_DIV_T: begin
                    if (w_ds_rsp.done) begin
                        r_t     <= w_ds_rsp.result[15:0];
                        r_k     <= '0;
                        r_state <= S_POS_MUL;
                    end
                end
                S_POS_MUL: begin
                    r_state <= S_POS_ADD;
                end
                S_POS_ADD: begin
                    r_pos[r_k] <= r_p_pos[r_k] + w_round[31:0];
                    if (r_k == 2'd2) begin
                        r_k     <= '0;
                        r_dot   <= '0;
                        r_state <= S_DOT_MUL;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_POS_MUL;
                    end
                end
                S_DOT_MUL: begin
                    r_state <= S_DOT_ADD;
                end
                S_DOT_ADD: begin
                    r_dot <= r_dot + w_prod[33:0];
                    if (r_k == 2'd3) begin
                        r_state <= S_DOT_END;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_DOT_MUL;
                    end
                end
                S_DOT_END: begin
                    for (int i = 0; i < 4; i++) begin
                        r_pq[i] <= {{2{r_p_rot[i][15]}}, r_p_rot[i], 14'd0};
                        r_nq[i] <= w_dot_neg
                                   ? (32'd0 - {{2{r_n_rot[i][15]}}, r_n_rot[i], 14'd0})
                                   : {{2{r_n_rot[i][15]}}, r_n_rot[i], 14'd0};
                    end
                    r_k <= '0;
                    if (w_dot_abs > DOT_LERP_LIMIT) begin
                        r_state <= S_LERP_MUL;
                    end else begin
                        r_bit   <= 4'd15;
                        r_state <= S_BIS_SUM;
                    end
                end
                S_LERP_MUL: begin
                    r_state <= S_LERP_ADD;
                end
                S_LERP_ADD: begin
                    r_s[r_k] <= r_pq[r_k] + w_round[31:0];
                    r_k      <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_final <= 1'b1;
                        r_sum   <= '0;
                        r_state <= S_NSQ_MUL;
                    end else begin
                        r_state <= S_LERP_MUL;
                    end
                end
                S_BIS_SUM: begin
                    for (int i = 0; i < 4; i++) begin
                        r_s[i] <= r_pq[i] + r_nq[i];
                    end
                    r_final <= 1'b0;
                    r_sum   <= '0;
                    r_k     <= '0;
                    r_state <= S_NSQ_MUL;
                end
                S_BIS_UPD: begin
                    for (int i = 0; i < 4; i++) begin
                        if (r_t[r_bit]) begin
                            r_pq[i] <= r_m[i];
                        end else begin
                            r_nq[i] <= r_m[i];
                        end
                    end
                    if (r_bit == 4'd0) begin
                        for (int i = 0; i < 4; i++) begin
                            r_s[i] <= r_t[0] ? r_m[i] : r_pq[i];
                        end
                        r_final <= 1'b1;
                        r_sum   <= '0;
                        r_k     <= '0;
                        r_state <= S_NSQ_MUL;
                    end else begin
                        r_bit   <= r_bit - 4'd1;
                        r_state <= S_BIS_SUM;
                    end
                end
                S_NSQ_MUL: begin
                    r_state <= S_NSQ_ADD;
                end
                S_NSQ_ADD: begin
                    r_sum <= r_sum + w_prod[63:0];
                    r_k   <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= S_NSQRT_GO;
                    end else begin
                        r_state <= S_NSQ_MUL;
                    end
                end
                S_NSQRT_GO: begin
                    r_state <= S_NSQRT;
                end
                S_NSQRT: begin
                    if (w_ds_rsp.done) begin
                        r_len   <= w_ds_rsp.result;
                        r_state <= S_NCHK;
                    end
                end
                S_NCHK: begin
                    r_k <= '0;
                    if (r_len > w_limit) begin
                        r_state <= S_NDIV_GO;
                    end else begin
                        for (int i = 0; i < 4; i++) begin
                            r_m[i] <= r_s[i];
                        end
                        r_state <= r_final ? S_FINISH : S_BIS_UPD;
                    end
                end
                S_NDIV_GO: begin
                    r_state <= S_NDIV_WAIT;
                end
                S_NDIV_WAIT: begin
                    if (w_ds_rsp.done) begin
                        r_m[r_k] <= r_s[r_k][31] ? (32'd0 - w_ds_rsp.result)
                                                 : w_ds_rsp.result;
                        r_k      <= r_k + 2'd1;
                        if (r_k == 2'd3) begin
                            r_state <= r_final ? S_FINISH : S_BIS_UPD;
                        end else begin
                            r_state <= S_NDIV_GO;
                        end
                    end
                end
                S_FINISH: begin
                    r_res.status    <= ST_INTERP;
                    r_res.out_pos_x <= r_pos[0];
                    r_res.out_pos_y <= r_pos[1];
                    r_res.out_pos_z <= r_pos[2];
                    r_res.out_rot_x <= w_orot[0];
                    r_res.out_rot_y <= w_orot[1];
                    r_res.out_rot_z <= w_orot[2];
                    r_res.out_rot_w <= w_orot[3];
                    r_state         <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready    = (r_state == S_IDLE) && i_rst_n;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // shared unit only runs while the sequencer waits on it
    a_ds_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ds_rsp.busy |-> (r_state == S_DIV_T || r_state == S_NSQRT
                           || r_state == S_NDIV_WAIT))
        else $error("shared unit busy outside a wait state");

    a_zero_pose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_HELD && r_out.status != ST_INTERP)
        |-> (r_out.out_pos_x == '0 && r_out.out_pos_z == '0 && r_out.out_rot_w == '0))
        else $error("pose not zero for a status without pose");

    a_take_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_DECODE && !i_in.ready))
        else $error("transfer not followed by decode");
endmodule

FILE: hw/rtl/sji_slots.sv
// snapshot ring memory with per-slot valid bits and registered read
module sji_slots import sji_pkg::*; #(
    parameter int SLOTS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(SLOTS)-1:0] i_waddr,
    input  t_slot                    i_wdata,
    input  logic [$clog2(SLOTS)-1:0] i_raddr,
    output t_slot                    o_rdata
);
    t_slot            r_mem [SLOTS];
    logic [SLOTS-1:0] r_valid;
    t_slot            r_rd;
    logic             r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rd_ok <= r_valid[i_raddr];
        end
    end

    // an unwritten slot reads as empty
    always_comb begin
        o_rdata = r_rd;
        if (!r_rd_ok) begin
            o_rdata.slot_time = '0;
        end
    end
endmodule

FILE: hw/rtl/sji_divsqrt.sv
// shared shift-subtract unit: restoring division or bit-pair square root
module sji_divsqrt import sji_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ds_cmd i_cmd,
    output t_ds_rsp o_rsp
);
    logic        r_busy;
    logic        r_done;
    logic        r_sqrt;
    logic [35:0] r_rem;
    logic [63:0] r_bits;
    logic [31:0] r_q;
    logic [31:0] r_div;
    logic [5:0]  r_cnt;

    logic [35:0] w_sh;
    logic [35:0] w_try;
    logic        w_ge;
    logic [35:0] w_diff;

    always_comb begin
        if (r_sqrt) begin
            w_sh  = {r_rem[33:0], r_bits[63:62]};
            w_try = {2'b00, r_q, 2'b01};
        end else begin
            w_sh  = {r_rem[34:0], r_bits[63]};
            w_try = {4'b0000, r_div};
        end
        w_ge   = (w_sh >= w_try);
        w_diff = w_sh - w_try;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sqrt <= i_cmd.is_sqrt;
            r_rem  <= i_cmd.init_rem;
            r_bits <= i_cmd.bits;
            r_q    <= '0;
            r_div  <= i_cmd.divisor;
            r_cnt  <= i_cmd.steps;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff : w_sh;
            r_q    <= {r_q[30:0], w_ge};
            r_bits <= r_sqrt ? {r_bits[61:0], 2'b00} : {r_bits[62:0], 1'b0};
            r_cnt  <= r_cnt - 6'd1;
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_q;
endmodule

FILE: hw/rtl/sji_mul.sv
// shared signed multiplier with registered product
module sji_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end
endmodule

FILE: dv/snapshot_jitter_interpolator_test.sv
// testbench of the snapshot jitter interpolator: directed and random items
`timescale 1ns / 1ps

module snapshot_jitter_interpolator_test;
    import sji_pkg::*;

    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;
    localparam int   NSLOT     = 8;
    localparam longint Q28_ONE = 64'sd1 << 28;

    typedef longint t_vec4 [4];

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    sji_in_if  in_ch ();
    sji_out_if out_ch ();

    snapshot_jitter_interpolator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [31:0]        snap_time [NSLOT];
    logic signed [31:0] snap_pos  [NSLOT][3];
    logic signed [15:0] snap_rot  [NSLOT][4];
    logic [15:0]        last_seq_p;
    int                 wr_slot_p;
    logic [15:0]        entity_p;
    logic               local_p;
    logic [15:0]        delay_p;

    t_out_item pose_queue [$];
    int        errors = 0;
    int        results_seen = 0;
    int        interp_seen = 0;
    int        stall_on = 1;
    int        gap_on = 1;
    int        hold_left = 0;
    int        stall_left = 0;

    // stimulus generator state
    logic [31:0]        cur_time;
    logic signed [15:0] base_rot [4];
    logic signed [31:0] cur_pos [3];

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_vec4 norm_vec(t_vec4 s, longint lim);
        t_vec4 o;
        longint unsigned sum, len;
        sum = 0;
        for (int i = 0; i < 4; i++) sum += longint'(s[i] * s[i]);
        len = isqrt(sum);
        for (int i = 0; i < 4; i++)
            o[i] = (longint'(len) > lim) ? (s[i] * Q28_ONE) / longint'(len) : s[i];
        return o;
    endfunction

    function automatic longint mix(longint a, longint b, longint t);
        return a + (((b - a) * t + 32768) >>> 16);
    endfunction

    function automatic t_out_item predict_pose(t_in_item it);
        t_out_item r;
        int prv, nxt;
        longint render, t, dot;
        longint unsigned span, num;
        t_vec4 p, n, q, s, m;
        logic [15:0] dseq;
        r = '0;
        prv = -1;
        nxt = -1;
        dot = 0;
        if (it.action == ACT_STORE) begin
            dseq = it.seq_number - last_seq_p;
            if (it.sender_id != entity_p || local_p) begin
                r.status = ST_IGNORED;
            end else if (dseq == 0 || dseq >= 16'h8000) begin
                r.status = ST_STALE;
            end else begin
                last_seq_p = it.seq_number;
                snap_time[wr_slot_p] = it.now_time;
                snap_pos[wr_slot_p][0] = it.in_pos_x;
                snap_pos[wr_slot_p][1] = it.in_pos_y;
                snap_pos[wr_slot_p][2] = it.in_pos_z;
                snap_rot[wr_slot_p][0] = it.in_rot_x;
                snap_rot[wr_slot_p][1] = it.in_rot_y;
                snap_rot[wr_slot_p][2] = it.in_rot_z;
                snap_rot[wr_slot_p][3] = it.in_rot_w;
                wr_slot_p = (wr_slot_p + 1) % NSLOT;
                r.status = ST_STORED;
            end
            return r;
        end
        if (local_p) begin
            r.status = ST_IGNORED;
            return r;
        end
        render = longint'({32'd0, it.now_time}) - longint'({48'd0, delay_p});
        for (int i = 0; i < NSLOT; i++) begin
            if (snap_time[i] == 0) continue;
            if (longint'({32'd0, snap_time[i]}) <= render) begin
                if (prv < 0 || snap_time[i] > snap_time[prv]) prv = i;
            end else begin
                if (nxt < 0 || snap_time[i] < snap_time[nxt]) nxt = i;
            end
        end
        if (prv < 0) begin
            r.status = ST_NO_DATA;
            return r;
        end
        if (nxt < 0) begin
            r.status = ST_HELD;
            r.out_pos_x = snap_pos[prv][0];
            r.out_pos_y = snap_pos[prv][1];
            r.out_pos_z = snap_pos[prv][2];
            r.out_rot_x = snap_rot[prv][0];
            r.out_rot_y = snap_rot[prv][1];
            r.out_rot_z = snap_rot[prv][2];
            r.out_rot_w = snap_rot[prv][3];
            return r;
        end
        span = {32'd0, snap_time[nxt]} - {32'd0, snap_time[prv]};
        num = longint'(render - longint'({32'd0, snap_time[prv]})) << 16;
        t = longint'(num / span);
        if (t > 65535) t = 65535;
        r.status = ST_INTERP;
        r.out_pos_x = 32'(mix(snap_pos[prv][0], snap_pos[nxt][0], t));
        r.out_pos_y = 32'(mix(snap_pos[prv][1], snap_pos[nxt][1], t));
        r.out_pos_z = 32'(mix(snap_pos[prv][2], snap_pos[nxt][2], t));
        for (int i = 0; i < 4; i++) begin
            p[i] = snap_rot[prv][i];
            n[i] = snap_rot[nxt][i];
            dot += p[i] * n[i];
        end
        if (dot < 0) begin
            for (int i = 0; i < 4; i++) n[i] = -n[i];
            dot = -dot;
        end
        for (int i = 0; i < 4; i++) begin
            p[i] *= 16384;
            n[i] *= 16384;
        end
        if (dot > longint'(DOT_LERP_LIMIT)) begin
            for (int i = 0; i < 4; i++) q[i] = mix(p[i], n[i], t);
        end else begin
            for (int b = 15; b >= 0; b--) begin
                for (int k = 0; k < 4; k++) s[k] = p[k] + n[k];
                m = norm_vec(s, 0);
                for (int k = 0; k < 4; k++) begin
                    if ((t >> b) & 1) p[k] = m[k];
                    else n[k] = m[k];
                end
            end
            q = p;
        end
        q = norm_vec(q, longint'(LEN_LIMIT));
        r.out_rot_x = 16'((q[0] + 8192) >>> 14);
        r.out_rot_y = 16'((q[1] + 8192) >>> 14);
        r.out_rot_z = 16'((q[2] + 8192) >>> 14);
        r.out_rot_w = 16'((q[3] + 8192) >>> 14);
        return r;
    endfunction

    // receiver readiness: random stalls and long holds
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (stall_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 12);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want, got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.payload;
            results_seen++;
            if (pose_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
            end else begin
                want = pose_queue.pop_front();
                if (want.status == ST_INTERP) interp_seen++;
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    task automatic send_item(t_in_item it);
        int gap;
        if (gap_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        pose_queue.push_back(predict_pose(it));
    endtask

    task automatic quiet_input();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        quiet_input();
        wait (pose_queue.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ENTITY_ID) entity_p = val;
        else if (idx == CFG_LOCAL) local_p = val[0];
        else if (idx == CFG_DELAY) delay_p = val;
    endtask

    function automatic t_in_item make_item(logic act, logic [15:0] id, logic [15:0] seq,
                                           logic [31:0] now, logic [31:0] px, logic [31:0] py,
                                           logic [31:0] pz, logic [15:0] rx, logic [15:0] ry,
                                           logic [15:0] rz, logic [15:0] rw);
        t_in_item it;
        it.action = act;
        it.sender_id = id;
        it.seq_number = seq;
        it.now_time = now;
        it.in_pos_x = px;
        it.in_pos_y = py;
        it.in_pos_z = pz;
        it.in_rot_x = rx;
        it.in_rot_y = ry;
        it.in_rot_z = rz;
        it.in_rot_w = rw;
        return it;
    endfunction

    function automatic logic [15:0] rand_comp();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic void pick_base_rot();
        int ax;
        if ($urandom_range(0, 1)) begin
            for (int i = 0; i < 4; i++)
                base_rot[i] = $urandom_range(0, 1) ? 16'sd8192 : -16'sd8192;
        end else begin
            ax = $urandom_range(0, 3);
            for (int i = 0; i < 4; i++)
                base_rot[i] = (i == ax)
                              ? ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384)
                              : 16'sd0;
        end
    endfunction

    function automatic t_in_item rand_store();
        t_in_item it;
        int kind;
        logic signed [15:0] rq [4];
        kind = $urandom_range(0, 99);
        cur_time = cur_time + $urandom_range(1, 3000);
        if (cur_time == 0) cur_time = 1;
        for (int i = 0; i < 3; i++)
            cur_pos[i] = $urandom_range(0, 1) ? $urandom()
                         : cur_pos[i] + $signed($urandom_range(0, 2000)) - 1000;
        for (int i = 0; i < 4; i++) begin
            rq[i] = base_rot[i] + $signed($urandom_range(0, 6)) - 3;
            if (rq[i] > 16384) rq[i] = 16384;
            if (rq[i] < -16384) rq[i] = -16384;
        end
        if ($urandom_range(0, 59) == 0)
            for (int i = 0; i < 4; i++) rq[i] = rand_comp();
        it = make_item(ACT_STORE, entity_p, last_seq_p + 16'($urandom_range(1, 4)), cur_time,
                       cur_pos[0], cur_pos[1], cur_pos[2], rq[0], rq[1], rq[2], rq[3]);
        if (kind < 5) it.sender_id = $urandom();
        else if (kind < 10) it.seq_number = last_seq_p + 16'($urandom_range(32768, 65536));
        else if (kind < 14) it.seq_number = $urandom();
        return it;
    endfunction

    function automatic t_in_item rand_query();
        t_in_item it;
        logic [31:0] now;
        if ($urandom_range(0, 9) == 0) now = cur_time - $urandom_range(0, 30000);
        else now = cur_time + $urandom_range(0, 9000);
        if (now == 0) now = 1;
        it = make_item(ACT_QUERY, $urandom(), $urandom(), now, $urandom(), $urandom(), $urandom(),
                       rand_comp(), rand_comp(), rand_comp(), rand_comp());
        return it;
    endfunction

    task automatic send_random(int count);
        repeat (count) begin
            if ($urandom_range(0, 1)) send_item(rand_store());
            else send_item(rand_query());
        end
    endtask

    task automatic test_directed();
        send_item(make_item(ACT_QUERY, 0, 0, 32'd100000, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ACT_STORE, 0, 0, 32'd1000, 1, 2, 3, 0, 0, 0, 16384));
        send_item(make_item(ACT_STORE, 16'hFFFF, 1, 32'd1000, 1, 2, 3, 0, 0, 0, 16384));
        send_item(make_item(ACT_STORE, 0, 1, 32'd10000, 32'h7FFFFFFF, 32'h80000000, 0,
                            0, 0, 0, 16384));
        send_item(make_item(ACT_QUERY, 0, 0, 32'd20000, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ACT_QUERY, 0, 0, 32'd1, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ACT_STORE, 0, 3, 32'd20000, 32'h80000000, 32'h7FFFFFFF, -1,
                            1, 0, 0, 16384));
        send_item(make_item(ACT_QUERY, 0, 0, 32'd23000, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ACT_STORE, 0, 16'h8003, 32'd25000, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ACT_STORE, 0, 4, 32'd30000, 5, 5, 5, 16384, 0, 0, 0));
        send_item(make_item(ACT_QUERY, 0, 0, 32'd32554, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ACT_STORE, 0, 5, 32'd40000, 0, 0, 0, -16384, 0, 0, 0));
        send_item(make_item(ACT_QUERY, 0, 0, 32'd43554, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ACT_STORE, 0, 6, 32'd40000, 9, 9, 9, 0, -16384, 0, 0));
        send_item(make_item(ACT_STORE, 0, 7, 32'd50000, 7, 7, 7, 0, 0, 0, 0));
        send_item(make_item(ACT_QUERY, 0, 0, 32'd53554, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ACT_STORE, 0, 8, 32'd0, 7, 7, 7, 0, 0, 0, 0));
        send_item(make_item(ACT_STORE, 0, 9, 32'hFFFFFFFF, -1, -1, -1,
                            -16384, -16384, -16384, -16384));
        send_item(make_item(ACT_QUERY, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();
        write_reg(CFG_LOCAL, 16'd1);
        send_item(make_item(ACT_STORE, 0, 10, 32'd60000, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ACT_QUERY, 16'hABCD, 0, 32'd60000, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();
        write_reg(CFG_LOCAL, 16'd0);
    endtask

    task automatic test_random_phases();
        logic [15:0] delays [4];
        delays[0] = 16'd0;
        delays[1] = 16'hFFFF;
        delays[2] = DELAY_RESET;
        for (int ph = 0; ph < 8; ph++) begin
            delays[3] = $urandom();
            wait_drained();
            write_reg(CFG_ENTITY_ID, (ph == 7) ? 16'hFFFF : 16'($urandom()));
            write_reg(CFG_DELAY, delays[ph % 4]);
            write_reg(CFG_LOCAL, (ph == 5) ? 16'd1 : 16'd0);
            pick_base_rot();
            cur_time = (ph == 3) ? 32'hFFFF0000 : $urandom_range(1, 32'h7FFFFFFF);
            send_random((ph == 5) ? 40 : 195);
        end
        wait_drained();
        write_reg(CFG_LOCAL, 16'd0);
    endtask

    task automatic test_backpressure();
        hold_left = 400;
        send_random(30);
        wait_drained();
    endtask

    task automatic test_sender_pause();
        send_random(40);
        wait_drained();
        send_random(40);
    endtask

    task automatic test_full_rate();
        wait_drained();
        gap_on = 0;
        stall_on = 0;
        send_random(200);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
            snap_time[i] = 0;
            for (int k = 0; k < 3; k++) snap_pos[i][k] = 0;
            for (int k = 0; k < 4; k++) snap_rot[i][k] = 0;
        end
        last_seq_p = 0;
        wr_slot_p = 0;
        entity_p = 0;
        local_p = 0;
        delay_p = DELAY_RESET;
        cur_time = 1;
        for (int i = 0; i < 3; i++) cur_pos[i] = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(negedge i_clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        test_sender_pause();
        test_full_rate();
        wait_drained();
        repeat (100) @(posedge i_clk);
        $display("covered %0d results, %0d of them interpolated, over 8 register settings",
                 results_seen, interp_seen);
        $display("stores, stale and foreign snapshots, holds, empty and negative render times");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("timeout with %0d results outstanding", pose_queue.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/sji_pkg.sv
hw/rtl/sji_if.sv
hw/rtl/sji_slots.sv
hw/rtl/sji_divsqrt.sv
hw/rtl/sji_mul.sv
hw/rtl/snapshot_jitter_interpolator.sv
dv/snapshot_jitter_interpolator_test.sv
